/* hw/rtl/gcm_pkg.sv */
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared constants, denomination table and controller/datapath interface
// types for the greedy change maker.
// ----------------------------------------------------------------------------
package gcm_pkg;

    // Field widths and default configuration
    localparam int AMOUNT_BITS_DEF = 24;
    localparam int NUM_DENOMS_DEF  = 15;
    localparam int TABLE_SIZE      = 15;
    localparam int INDEX_BITS      = 4;
    localparam int DENOM_BITS      = 16;
    localparam int COUNT_BITS      = 24;

    // Smallest banknote value, in cents
    localparam logic [DENOM_BITS-1:0] NOTE_MIN_CENTS = 16'd500;

    // Denomination in cents for a table position, largest first
    function automatic logic [DENOM_BITS-1:0] denom_value(input logic [INDEX_BITS-1:0] idx);
        logic [DENOM_BITS-1:0] val;
        unique case (idx)
            4'd0:    val = 16'd50000;
            4'd1:    val = 16'd20000;
            4'd2:    val = 16'd10000;
            4'd3:    val = 16'd5000;
            4'd4:    val = 16'd2000;
            4'd5:    val = 16'd1000;
            4'd6:    val = 16'd500;
            4'd7:    val = 16'd200;
            4'd8:    val = 16'd100;
            4'd9:    val = 16'd50;
            4'd10:   val = 16'd20;
            4'd11:   val = 16'd10;
            4'd12:   val = 16'd5;
            4'd13:   val = 16'd2;
            default: val = 16'd1;
        endcase
        return val;
    endfunction

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // take a new amount, rewind the table index
        logic next_denom;  // advance to the next denomination
        logic start_div;   // start dividing the remaining amount
        logic div_step;    // one restoring division step
        logic commit;      // remainder becomes the remaining amount
        logic emit;        // load the result register
    } gcm_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic rem_zero;    // nothing left to pay
        logic skip;        // current denomination is a disabled note
        logic div_done;    // last division step is in progress
        logic quot_zero;   // current denomination is not used
        logic out_free;    // result register can take a beat this cycle
    } gcm_status_t;

endpackage

/* hw/rtl/gcm_ctrl.sv */
// ----------------------------------------------------------------------------
// gcm_ctrl
// Sequencer for the change maker: walks the denomination table, runs one
// division per enabled denomination and hands results to the output register.
// ----------------------------------------------------------------------------
module gcm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gcm_pkg::gcm_status_t status,
    output gcm_pkg::gcm_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIVIDE,
        ST_CHECK,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (status.rem_zero) begin
                    state_next = ST_IDLE;
                end else if (status.skip) begin
                    cmd.next_denom = 1'b1;
                end else begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.commit = 1'b1;
                if (status.quot_zero) begin
                    cmd.next_denom = 1'b1;
                    state_next     = ST_TEST;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the result register frees up
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.rem_zero) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.next_denom = 1'b1;
                        state_next     = ST_TEST;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/gcm_datapath.sv */
// ----------------------------------------------------------------------------
// gcm_datapath
// Remaining amount, table index, bit-serial restoring divider and the
// result register with its valid flag.
// ----------------------------------------------------------------------------
module gcm_datapath #(
    parameter int AMOUNT_BITS = gcm_pkg::AMOUNT_BITS_DEF,
    parameter int NUM_DENOMS  = gcm_pkg::NUM_DENOMS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic [AMOUNT_BITS-1:0]          s_amount_cents,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gcm_pkg::DENOM_BITS-1:0]  m_denomination_cents,
    output logic [gcm_pkg::COUNT_BITS-1:0]  m_piece_count,
    output logic                            m_last_piece,
    input  gcm_pkg::gcm_cmd_t               cmd,
    output gcm_pkg::gcm_status_t            status
);

    localparam int NUM_USED   = (NUM_DENOMS < 1) ? 1 :
                                ((NUM_DENOMS > gcm_pkg::TABLE_SIZE) ?
                                 gcm_pkg::TABLE_SIZE : NUM_DENOMS);
    localparam logic [gcm_pkg::INDEX_BITS-1:0] FIRST_IDX =
        gcm_pkg::INDEX_BITS'(gcm_pkg::TABLE_SIZE - NUM_USED);
    localparam int STEP_BITS  = $clog2(AMOUNT_BITS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(AMOUNT_BITS - 1);
    localparam int DB         = gcm_pkg::DENOM_BITS;
    localparam int CB         = gcm_pkg::COUNT_BITS;

    logic                            include_notes_reg;
    logic [gcm_pkg::INDEX_BITS-1:0]  idx_reg;
    logic [AMOUNT_BITS-1:0]          remaining_reg;
    logic [AMOUNT_BITS-1:0]          dividend_reg;   // shifts out dividend, shifts in quotient
    logic [DB-1:0]                   prem_reg;       // partial remainder
    logic [STEP_BITS-1:0]            step_reg;
    logic                            out_valid_reg;
    logic [DB-1:0]                   out_denom_reg;
    logic [CB-1:0]                   out_count_reg;
    logic                            out_last_reg;

    logic [DB-1:0]                   denom;
    logic [DB:0]                     trial;
    logic                            fits;
    logic [DB-1:0]                   prem_next;
    logic [AMOUNT_BITS+DB-1:0]       rem_wide;
    logic [AMOUNT_BITS+CB-1:0]       quot_wide;
    logic                            out_free;

    // Current denomination and one restoring division step
    always_comb begin
        denom     = gcm_pkg::denom_value(idx_reg);
        trial     = {prem_reg, dividend_reg[AMOUNT_BITS-1]};
        fits      = (trial >= {1'b0, denom});
        prem_next = fits ? DB'(trial - {1'b0, denom}) : trial[DB-1:0];
        rem_wide  = {{AMOUNT_BITS{1'b0}}, prem_reg};
        quot_wide = {{CB{1'b0}}, dividend_reg};
        out_free  = !out_valid_reg || m_ready;
    end

    // Status to the controller
    always_comb begin
        status.rem_zero  = (remaining_reg == '0);
        status.skip      = !include_notes_reg && (denom >= gcm_pkg::NOTE_MIN_CENTS);
        status.div_done  = (step_reg == '0);
        status.quot_zero = (dividend_reg == '0);
        status.out_free  = out_free;
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            include_notes_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            include_notes_reg <= cfg_wr_data;
        end
    end

    // Amount, index and divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            remaining_reg <= '0;
        end else begin
            if (cmd.load) begin
                remaining_reg <= s_amount_cents;
                idx_reg       <= FIRST_IDX;
            end else begin
                if (cmd.commit) begin
                    remaining_reg <= rem_wide[AMOUNT_BITS-1:0];
                end
                if (cmd.next_denom) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_div) begin
            dividend_reg <= remaining_reg;
            prem_reg     <= '0;
            step_reg     <= LAST_STEP;
        end else if (cmd.div_step) begin
            dividend_reg <= {dividend_reg[AMOUNT_BITS-2:0], fits};
            prem_reg     <= prem_next;
            step_reg     <= step_reg - 1'b1;
        end
    end

    // Result register: load on emit, drop valid when the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_denom_reg <= denom;
            out_count_reg <= quot_wide[CB-1:0];
            out_last_reg  <= (remaining_reg == '0);
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_denomination_cents = out_denom_reg;
    assign m_piece_count        = out_count_reg;
    assign m_last_piece         = out_last_reg;

endmodule

/* hw/rtl/greedy_change_maker_unit.sv */
// ----------------------------------------------------------------------------
// greedy_change_maker_unit
// Greedy euro change maker: splits an amount in cents into denominations.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_amount_cents carry one amount in cents per beat.
//   m_valid/m_ready carry one beat per denomination used, largest first,
//   with the denomination, its piece count and m_last_piece on the final
//   beat of an amount. An amount of zero produces no beats.
//   cfg_wr_en/cfg_wr_data write include_notes (reset 1) while the block is
//   idle; with it clear, only coins of 2 euro and below are used.
// Timing:
//   Each denomination examined passes through a test state; each one not
//   skipped then runs a bit-serial restoring divide over AMOUNT_BITS
//   quotient bits, a check state and, if the denomination is used, an emit
//   state. s_ready is high only between items.
// Reset and stall:
//   aresetn clears the sequencer and output valid and sets include_notes.
//   A finished beat waits in the output register; while it is stalled the
//   sequencer holds before the next beat, and after the last beat of an
//   amount the next amount can be taken at once.
// ----------------------------------------------------------------------------
module greedy_change_maker_unit #(
    parameter int AMOUNT_BITS = gcm_pkg::AMOUNT_BITS_DEF,
    parameter int NUM_DENOMS  = gcm_pkg::NUM_DENOMS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [AMOUNT_BITS-1:0]          s_amount_cents,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gcm_pkg::DENOM_BITS-1:0]  m_denomination_cents,
    output logic [gcm_pkg::COUNT_BITS-1:0]  m_piece_count,
    output logic                            m_last_piece
);

    gcm_pkg::gcm_cmd_t    cmd;
    gcm_pkg::gcm_status_t status;

    // Sequencer
    gcm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Divider, index and result register
    gcm_datapath #(
        .AMOUNT_BITS (AMOUNT_BITS),
        .NUM_DENOMS  (NUM_DENOMS)
    ) u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_amount_cents       (s_amount_cents),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_denomination_cents (m_denomination_cents),
        .m_piece_count        (m_piece_count),
        .m_last_piece         (m_last_piece),
        .cmd                  (cmd),
        .status               (status)
    );

endmodule

/* hw/rtl/gcm_checker.sv */
// ----------------------------------------------------------------------------
// gcm_checker
// Port-level checks for the greedy change maker, bound to the top level.
// ----------------------------------------------------------------------------
module gcm_checker #(
    parameter int AMOUNT_BITS = gcm_pkg::AMOUNT_BITS_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [AMOUNT_BITS-1:0]          s_amount_cents,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [gcm_pkg::DENOM_BITS-1:0]  m_denomination_cents,
    input logic [gcm_pkg::COUNT_BITS-1:0]  m_piece_count,
    input logic                            m_last_piece
);

    // A stalled beat holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_denomination_cents)
            && $stable(m_piece_count) && $stable(m_last_piece))
        else $error("stalled result beat changed");

    // Every beat gives at least one piece of a real denomination
    a_out_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_piece_count != '0) && (m_denomination_cents != '0))
        else $error("result beat with zero count or denomination");

    // An accepted amount closes the input right after it is taken
    a_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted amount");

    // A nonzero amount cannot return to idle straight from its first test state
    a_no_early_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_amount_cents != '0) |=> ##1 !s_ready)
        else $error("nonzero amount finished too early");

endmodule

bind greedy_change_maker_unit gcm_checker #(
    .AMOUNT_BITS (AMOUNT_BITS)
) u_gcm_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_valid              (s_valid),
    .s_ready              (s_ready),
    .s_amount_cents       (s_amount_cents),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_denomination_cents (m_denomination_cents),
    .m_piece_count        (m_piece_count),
    .m_last_piece         (m_last_piece)
);

/* sim/greedy_change_maker_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_change_maker_unit_tb
// Drives amounts in cents into the change maker and checks every result beat
// (denomination, piece count, last flag) against a greedy euro change
// predictor kept in step with the include_notes setting. Both channels stall
// at random, with one long receiver hold-off and several full drains.
// ----------------------------------------------------------------------------
module greedy_change_maker_unit_tb;

    localparam int AMT_W         = gcm_pkg::AMOUNT_BITS_DEF;
    localparam int SETTLE_CYCLES = 450;
    localparam int HOLD_CYCLES   = 1500;

    // One result beat as the block presents it
    typedef struct packed {
        logic [gcm_pkg::DENOM_BITS-1:0] denom;
        logic [gcm_pkg::COUNT_BITS-1:0] count;
        logic                           last;
    } change_beat_t;

    logic                           aclk           = 1'b0;
    logic                           aresetn        = 1'b0;
    logic                           cfg_wr_en      = 1'b0;
    logic                           cfg_wr_data    = 1'b0;
    logic                           s_valid        = 1'b0;
    logic                           s_ready;
    logic [AMT_W-1:0]               s_amount_cents = '0;
    logic                           m_valid;
    logic                           m_ready        = 1'b0;
    logic [gcm_pkg::DENOM_BITS-1:0] m_denomination_cents;
    logic [gcm_pkg::COUNT_BITS-1:0] m_piece_count;
    logic                           m_last_piece;

    // Euro pieces in cents, largest first
    int unsigned euro_denoms [15] = '{50000, 20000, 10000, 5000, 2000, 1000, 500,
                                      200, 100, 50, 20, 10, 5, 2, 1};

    change_beat_t expected_change[$];
    logic         notes_enabled = 1'b1;
    bit           idle_on       = 1'b1;
    bit           hold_off_req  = 1'b0;
    int           hold_left     = 0;
    int           stall_left    = 0;
    int           error_count   = 0;

    greedy_change_maker_unit uut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_amount_cents       (s_amount_cents),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_denomination_cents (m_denomination_cents),
        .m_piece_count        (m_piece_count),
        .m_last_piece         (m_last_piece)
    );

    always begin
        #5 aclk = 1'b0;
        #5 aclk = 1'b1;
    end

    // Queue the beats that greedy change for one amount should produce
    function automatic void predict_change(input logic [AMT_W-1:0] amount);
        int unsigned  left;
        int unsigned  pieces;
        bit           have_beat;
        change_beat_t beat;
        left      = 32'(amount);
        have_beat = 1'b0;
        beat      = '0;
        for (int k = 0; k < 15; k++) begin
            if (left == 0) break;
            if (!notes_enabled && euro_denoms[k] >= gcm_pkg::NOTE_MIN_CENTS) continue;
            pieces = left / euro_denoms[k];
            if (pieces == 0) continue;
            left = left - pieces * euro_denoms[k];
            // hold back each beat until we know whether another follows
            if (have_beat) expected_change = {expected_change, beat};
            beat.denom = euro_denoms[k][gcm_pkg::DENOM_BITS-1:0];
            beat.count = pieces[gcm_pkg::COUNT_BITS-1:0];
            beat.last  = 1'b0;
            have_beat  = 1'b1;
        end
        if (have_beat) begin
            beat.last = 1'b1;
            expected_change = {expected_change, beat};
        end
    endfunction

    // Mix of zero, small, mid-size, exact-multiple, near-max and full-range amounts
    function automatic logic [AMT_W-1:0] random_amount();
        int unsigned pick;
        int unsigned mult;
        pick = $urandom_range(0, 11);
        case (pick)
            0: begin
                random_amount = '0;
            end
            1, 2, 3: begin
                random_amount = AMT_W'($urandom_range(1, 999));
            end
            4, 5: begin
                random_amount = AMT_W'($urandom_range(1, 99999));
            end
            6, 7: begin
                mult = $urandom_range(1, 40) * euro_denoms[$urandom_range(0, 14)];
                random_amount = mult[AMT_W-1:0];
            end
            8: begin
                random_amount = {AMT_W{1'b1}} - AMT_W'($urandom_range(0, 2000));
            end
            default: begin
                random_amount = AMT_W'($urandom());
            end
        endcase
    endfunction

    // Offer one amount and hold it until the beat is taken
    task automatic send_amount(input logic [AMT_W-1:0] amount);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_amount_cents <= amount;
        do @(posedge aclk); while (!s_ready);
        predict_change(amount);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_change.size() != 0);
    endtask

    // Drain, then give a zero amount time to finish before touching config
    task automatic settle_idle();
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_notes_flag(input logic flag);
        settle_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= flag;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        notes_enabled = flag;
    endtask

    // Edge amounts, exact pieces and one of every denomination
    task automatic run_directed_amounts();
        logic [AMT_W-1:0] picks [$];
        picks = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd88888, 24'd50000, 24'd49999,
                  24'd500, 24'd499, 24'hFFFFFF, 24'd0, 24'd100, 24'd8800000};
        foreach (picks[i]) send_amount(picks[i]);
    endtask

    // Same kinds of amounts with notes switched off
    task automatic check_coins_only();
        logic [AMT_W-1:0] picks [$];
        picks = '{24'd88888, 24'd500, 24'd50000, 24'hFFFFFF, 24'd199,
                  24'd0, 24'd1, 24'd777};
        write_notes_flag(1'b0);
        foreach (picks[i]) send_amount(picks[i]);
    endtask

    // Stall the output for a long stretch while amounts keep coming
    task automatic check_output_stall();
        write_notes_flag(1'b1);
        hold_off_req = 1'b1;
        repeat (12) send_amount(AMT_W'($urandom_range(1, 999999)));
    endtask

    // Pause the sender until every expected beat is back
    task automatic check_drain_pause();
        repeat (5) send_amount(random_amount());
        wait_for_drain();
        repeat (5) send_amount(random_amount());
    endtask

    // Random amounts over alternating settings
    task automatic run_random_amounts();
        for (int phase = 0; phase < 4; phase++) begin
            write_notes_flag(phase[0]);
            repeat (60) send_amount(random_amount());
        end
    endtask

    // Back-to-back beats with no idling on either side
    task automatic run_steady_stream();
        write_notes_flag(1'b1);
        idle_on = 1'b0;
        repeat (40) send_amount(random_amount());
    endtask

    // Receiver pacing: long hold-off on request, else random stall bursts
    always @(posedge aclk) begin
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 18);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each accepted beat with the oldest expectation
    always @(posedge aclk) begin : check_change
        change_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_change.size() == 0) begin
                $display("%0t: unexpected beat: expected none, actual %0d x %0d last %0b",
                         $time, m_denomination_cents, m_piece_count, m_last_piece);
                error_count++;
            end else begin
                want = expected_change.pop_front();
                if (m_denomination_cents !== want.denom) begin
                    $display("%0t: denomination mismatch: expected %0d actual %0d",
                             $time, want.denom, m_denomination_cents);
                    error_count++;
                end
                if (m_piece_count !== want.count) begin
                    $display("%0t: piece count mismatch: expected %0d actual %0d",
                             $time, want.count, m_piece_count);
                    error_count++;
                end
                if (m_last_piece !== want.last) begin
                    $display("%0t: last flag mismatch: expected %0b actual %0b",
                             $time, want.last, m_last_piece);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed_amounts();
        check_coins_only();
        check_output_stall();
        check_drain_pause();
        run_random_amounts();
        run_steady_stream();
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
